/* hw/rtl/upd_pkg.sv */
// Shared types, character constants and helper functions for the URL percent decoder.
`default_nettype none

package upd_pkg;

    // Characters with a special meaning in the encoded string.
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_PCT   = 8'h25;
    localparam logic [7:0] CHR_QMARK = 8'h3F;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Decoded bytes that one input character gives, in output order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } entry_t;

    // A plain character decodes to itself, except that a plus sign is a space.
    function automatic logic [7:0] plain_map(input logic [7:0] c);
        logic [7:0] r;
        r = (c == CHR_PLUS) ? CHR_SPACE : c;
        return r;
    endfunction

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    // Nibble value of a character already known to be a hex digit.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] r;
        r = c[6] ? (c[3:0] + 4'd9) : c[3:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/upd_front.sv */
// Front end: tracks escape state and turns each character into a group of decoded bytes.
`default_nettype none

module upd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_char,
    input  wire logic          s_in_last,
    input  wire logic          q_full,
    output logic               push,
    output upd_pkg::entry_t    push_entry
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    logic [1:0]      phase_reg;
    logic [1:0]      phase_next;
    logic [7:0]      held_reg;
    logic            accept;
    upd_pkg::entry_t ent;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Work out the bytes this character releases and the next escape state.
    always_comb begin
        ent.bytes  = '0;
        ent.cnt    = 2'd0;
        ent.last   = s_in_last;
        phase_next = PH_IDLE;
        case (phase_reg)
            PH_PCT: begin
                if (!s_in_last) begin
                    phase_next = PH_HELD;
                end else begin
                    // Escape cut short by end of string.
                    ent.bytes[0] = upd_pkg::CHR_QMARK;
                    ent.bytes[1] = (s_in_char == upd_pkg::CHR_PCT) ? upd_pkg::CHR_QMARK
                                                                   : upd_pkg::plain_map(s_in_char);
                    ent.cnt = 2'd2;
                end
            end
            PH_HELD: begin
                if (upd_pkg::is_hex(held_reg) && upd_pkg::is_hex(s_in_char)) begin
                    ent.bytes[0] = {upd_pkg::hex_val(held_reg), upd_pkg::hex_val(s_in_char)};
                    ent.cnt      = 2'd1;
                end else begin
                    ent.bytes[0] = upd_pkg::CHR_QMARK;
                    if (held_reg == upd_pkg::CHR_PCT) begin
                        // The held percent sign opens a new escape with this character.
                        if (s_in_last) begin
                            ent.bytes[1] = upd_pkg::CHR_QMARK;
                            ent.bytes[2] = (s_in_char == upd_pkg::CHR_PCT)
                                           ? upd_pkg::CHR_QMARK
                                           : upd_pkg::plain_map(s_in_char);
                            ent.cnt = 2'd3;
                        end else begin
                            ent.cnt    = 2'd1;
                            phase_next = PH_HELD;
                        end
                    end else begin
                        ent.bytes[1] = upd_pkg::plain_map(held_reg);
                        if (s_in_char == upd_pkg::CHR_PCT) begin
                            if (s_in_last) begin
                                ent.bytes[2] = upd_pkg::CHR_QMARK;
                                ent.cnt      = 2'd3;
                            end else begin
                                ent.cnt    = 2'd2;
                                phase_next = PH_PCT;
                            end
                        end else begin
                            ent.bytes[2] = upd_pkg::plain_map(s_in_char);
                            ent.cnt      = 2'd3;
                        end
                    end
                end
            end
            default: begin
                if (s_in_char == upd_pkg::CHR_PCT) begin
                    if (s_in_last) begin
                        ent.bytes[0] = upd_pkg::CHR_QMARK;
                        ent.cnt      = 2'd1;
                    end else begin
                        phase_next = PH_PCT;
                    end
                end else begin
                    ent.bytes[0] = upd_pkg::plain_map(s_in_char);
                    ent.cnt      = 2'd1;
                end
            end
        endcase
    end

    // Only characters that release bytes take a queue slot.
    assign push       = accept && (ent.cnt != 2'd0);
    assign push_entry = ent;

    // Escape state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    // Character held after a percent sign; only read while an escape is half done.
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= s_in_char;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/upd_queue.sv */
// Short queue of decoded byte groups between the front and back ends.
`default_nettype none

module upd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire upd_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output upd_pkg::entry_t       head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/upd_back.sv */
// Back end: sends the bytes of each queued group one per cycle while m_ready allows, through an output register.
`default_nettype none

module upd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire upd_pkg::entry_t  head_entry,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_out_last
);

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_last_reg;
    logic       load;
    logic       final_byte;

    // The output register takes a new byte whenever one is queued and the register is empty or being drained.
    assign load       = head_valid && (!m_valid_reg || m_ready);
    assign final_byte = (idx_reg == (head_entry.cnt - 2'd1));
    assign pop        = load && final_byte;

    // Control: output valid and the byte position inside the current group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= final_byte ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg <= head_entry.bytes[idx_reg];
            m_last_reg <= head_entry.last && final_byte;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/url_percent_decoder.sv */
// Top level of the URL percent decoder: front end, byte-group queue and back end.
//
// Usage:
//   Input channel (s_valid/s_ready, s_in_char, s_in_last) takes one encoded
//   character per transaction; s_in_last marks the end of a string.
//   Output channel (m_valid/m_ready, m_out_byte, m_out_last) gives one decoded
//   byte per transaction; m_out_last is set on the final byte of a string.
//   A character releases zero to three bytes. It is classified in the cycle it
//   is accepted and its bytes are written into the queue; from there the first
//   byte is loaded into the output register.
//   Throughput is one character per cycle while each releases at most one byte
//   and m_ready stays high; the output side sends one byte per cycle while m_ready
//   is high, so a group of two or three bytes holds it longer, which the queue absorbs.
//   s_ready is low only while the queue of QUEUE_DEPTH groups is full.
//   Reset (aresetn low, synchronous) clears the escape state, empties the
//   queue and drops m_valid. When the receiver stalls, the output holds its
//   transaction and the queue fills before s_ready falls.
`default_nettype none

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last
);

    logic            q_full;
    logic            push;
    upd_pkg::entry_t push_entry;
    logic            pop;
    logic            head_valid;
    upd_pkg::entry_t head_entry;

    upd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_in_last  (s_in_last),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

`default_nettype wire

/* hw/rtl/upd_checker.sv */
// Port-level checks for the URL percent decoder, bound to the top level.
`default_nettype none

module upd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_in_last,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_out_last
);

    logic [3:0] open_strings_reg;
    logic       in_end;
    logic       out_end;

    assign in_end  = s_valid && s_ready && s_in_last;
    assign out_end = m_valid && m_ready && m_out_last;

    // Strings whose end was accepted but whose final byte has not left yet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_strings_reg <= 4'd0;
        end else if (in_end && !out_end) begin
            open_strings_reg <= open_strings_reg + 4'd1;
        end else if (out_end && !in_end) begin
            open_strings_reg <= open_strings_reg - 4'd1;
        end
    end

    // A stalled output transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("output transaction changed while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // The queue is empty when reset is released, so input is taken at once.
    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_ready)
        else $error("s_ready low right after reset");

    // A string end appears on the output only after one was accepted.
    a_last_follows_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_last |-> open_strings_reg != 4'd0)
        else $error("m_out_last without an accepted end of string");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_in_last  (s_in_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last)
);

`default_nettype wire

/* tb/url_decode_checker.sv */
// Checker for the URL percent decoder: predicts the decoded bytes and compares each output transaction.
`timescale 1ns / 100ps

module url_decode_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_last,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_out_byte,
    input  wire logic       m_out_last,
    output int              mismatch_count,
    output int              pending_count
);

    localparam int MAX_BYTES_PER_CHAR = 3;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_HELD
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    // Escape state of the predictor, mirroring the block.
    esc_phase_t esc_phase = ESC_NONE;
    logic [7:0] held_char = 8'h00;

    // Bytes released by the character being decoded, and all bytes still owed.
    logic [7:0] char_bytes[$];
    dec_byte_t  owed_bytes[$];

    int fail_total = 0;
    int owed_total = 0;

    assign mismatch_count = fail_total;
    assign pending_count  = owed_total;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    // Nibble value of a hex digit in either case, or -1 for anything else.
    function automatic int hex_nibble(input logic [7:0] c);
        int v;
        v = -1;
        if (c >= 8'h30 && c <= 8'h39) v = int'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = int'(c - 8'h41) + 10;
        else if (c >= 8'h61 && c <= 8'h66) v = int'(c - 8'h61) + 10;
        return v;
    endfunction

    function automatic void release_byte(input logic [7:0] b);
        if (char_bytes.size() < MAX_BYTES_PER_CHAR) char_bytes = {char_bytes, b};
    endfunction

    // A character seen with no complete escape to finish: hold it, open an escape with it or decode it plainly.
    function automatic void decode_plain(input logic [7:0] c);
        if (esc_phase == ESC_PCT) begin
            held_char = c;
            esc_phase = ESC_HELD;
        end else begin
            esc_phase = ESC_NONE;
            if (c == upd_pkg::CHR_PCT) esc_phase = ESC_PCT;
            else if (c == upd_pkg::CHR_PLUS) release_byte(upd_pkg::CHR_SPACE);
            else release_byte(c);
        end
    endfunction

    // Full decode of one character. A bad escape gives a question mark, then the
    // held character is decoded again from the idle state, followed by this one.
    function automatic void decode_char(input logic [7:0] c);
        logic [7:0] h;
        int         hi;
        int         lo;
        logic [7:0] value;
        if (esc_phase == ESC_HELD) begin
            h = held_char;
            hi = hex_nibble(h);
            lo = hex_nibble(c);
            esc_phase = ESC_NONE;
            held_char = 8'h00;
            if (hi >= 0 && lo >= 0) begin
                value = {hi[3:0], lo[3:0]};
                release_byte(value);
            end else begin
                release_byte(upd_pkg::CHR_QMARK);
                decode_plain(h);
                decode_plain(c);
            end
        end else begin
            decode_plain(c);
        end
    endfunction

    // At the end of a string any pending escape is flushed as question marks
    // and the held character is decoded on its own.
    function automatic void close_string();
        logic [7:0] h;
        while (esc_phase != ESC_NONE) begin
            if (esc_phase == ESC_PCT) begin
                release_byte(upd_pkg::CHR_QMARK);
                esc_phase = ESC_NONE;
            end else begin
                h = held_char;
                release_byte(upd_pkg::CHR_QMARK);
                esc_phase = ESC_NONE;
                held_char = 8'h00;
                decode_plain(h);
            end
        end
        held_char = 8'h00;
    endfunction

    task automatic predict_char(input logic [7:0] c, input logic last);
        dec_byte_t b;
        char_bytes.delete();
        decode_char(c);
        if (last) close_string();
        foreach (char_bytes[i]) begin
            b.data = char_bytes[i];
            b.last = last && (i == char_bytes.size() - 1);
            owed_bytes = {owed_bytes, b};
        end
    endtask

    // Watch both channels at each rising edge.
    always @(posedge aclk) begin
        dec_byte_t want;
        if (!aresetn) begin
            esc_phase = ESC_NONE;
            held_char = 8'h00;
            owed_bytes.delete();
        end else begin
            if (s_valid && s_ready) predict_char(s_in_char, s_in_last);
            if (m_valid && m_ready) begin
                if (owed_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b",
                                              m_out_byte, m_out_last));
                end else begin
                    want = owed_bytes.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %h, wanted %h",
                                                  m_out_byte, want.data));
                    if (m_out_last !== want.last)
                        report_mismatch($sformatf("out_last %b, wanted %b (byte %h)",
                                                  m_out_last, want.last, want.data));
                end
            end
        end
        owed_total = owed_bytes.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the URL percent decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_CHARS = 196;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_in_char = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    int mismatch_count;
    int pending_count;

    // Encoded characters waiting to be sent, in order.
    enc_char_t char_plan[$];

    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    always #6 aclk = ~aclk;

    url_percent_decoder dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    url_decode_checker u_decode_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_char      (s_in_char),
        .s_in_last      (s_in_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_last     (m_out_last),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic void plan_char(input logic [7:0] c, input logic last);
        enc_char_t e;
        e.ch = c;
        e.last = last;
        char_plan = {char_plan, e};
    endfunction

    function automatic void plan_text(input string s);
        for (int i = 0; i < s.len(); i++) plan_char(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        logic [7:0] c;
        if (n < 4'd10) c = 8'h30 + {4'h0, n};
        else c = (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
        return c;
    endfunction

    // One random string: mostly well-formed escapes and plain text, with some
    // plus signs, broken escapes and lone percent signs mixed in.
    function automatic void plan_random_string();
        logic [7:0] text[$];
        int         tokens;
        int         pick;
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                text = {text, upd_pkg::CHR_PCT};
                text = {text, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
                text = {text, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
            end else if (pick < 50) begin
                text = {text, upd_pkg::CHR_PLUS};
            end else if (pick < 62) begin
                text = {text, upd_pkg::CHR_PCT};
                text = {text, 8'($urandom_range(1, 255))};
                if ($urandom_range(0, 1)) text = {text, 8'($urandom_range(1, 255))};
            end else if (pick < 68) begin
                text = {text, upd_pkg::CHR_PCT};
            end else begin
                text = {text, 8'($urandom_range(1, 255))};
            end
        end
        foreach (text[i]) plan_char(text[i], i == text.size() - 1);
    endfunction

    // Stimulus: directed strings, then random strings, then drain and verdict.
    initial begin
        enc_char_t item;
        int        gap;
        int        sent;
        int        directed;
        sent = 0;

        // Extremes, plus sign, valid escapes in both cases, bad escapes and
        // strings that end with an escape pending.
        plan_char("a", 1'b0);
        plan_char(upd_pkg::CHR_PLUS, 1'b0);
        plan_char(8'hFF, 1'b0);
        plan_char(8'h01, 1'b1);
        plan_text("%41%7e%Ff");
        plan_text("%G1");
        plan_text("%%%");
        plan_text("%4");
        plan_text("%");
        plan_text("%%");
        directed = char_plan.size();
        while (char_plan.size() < directed + RANDOM_CHARS) plan_random_string();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (char_plan.size() > 0) begin
            item = char_plan.pop_front();
            if (sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
            gap = send_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_in_char <= item.ch;
            s_in_last <= item.last;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
            sent++;
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("url_percent_decoder regression: pass");
        end else begin
            $display("url_percent_decoder regression: fail");
        end
        $finish;
    end

    // Receiver: a random stall before each output transaction, with quiet stretches.
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
            stall = recv_quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("url_percent_decoder regression: fail");
        $finish;
    end

endmodule
